>>> design/qrp_pkg.sv
package qrp_pkg;

   localparam int ANG_W = 28;
   typedef logic signed [ANG_W-1:0] ang_type;

   localparam int ERR_W = 30;
   typedef logic signed [ERR_W-1:0] err_type;

   localparam int ROT_W = 33;
   typedef logic signed [ROT_W-1:0] rot_type;

   localparam int NORM_W = 31;
   localparam int ITER_W = 34;
   localparam int YAW_W = 34;
   localparam int AQ_W = 18;
   localparam int R_W = 37;
   localparam int G_W = 20;
   localparam int P_W = 56;

   localparam int ATAN_LEN = 24;

   localparam ang_type ANG_PI = 28'sd52707179;
   localparam err_type ANG_TWO_PI = 30'sd105414357;
   localparam rot_type INV_GAIN = 33'sd652032874;
   localparam logic signed [35:0] UNIT_ONE = 36'sd1073676289;
   localparam logic signed [15:0] Q13_LIMIT = 16'sd25736;

   localparam ang_type ATAN_TAB [ATAN_LEN] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
      28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
      28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
      28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
      28'sd256, 28'sd128, 28'sd64, 28'sd32,
      28'sd16, 28'sd8, 28'sd4, 28'sd2
   };

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [G_W-1:0] g00;
      logic signed [G_W-1:0] g01;
      logic signed [G_W-1:0] g02;
      logic signed [G_W-1:0] g20;
      logic signed [G_W-1:0] g21;
      logic signed [G_W-1:0] g22;
   } gmat_type;

   function automatic logic signed [15:0] to_q13(input ang_type a);
      ang_type t;
      t = (a + ang_type'(1024)) >>> 11;
      if (t > ang_type'(Q13_LIMIT)) begin
         return Q13_LIMIT;
      end
      if (t < -ang_type'(Q13_LIMIT)) begin
         return -Q13_LIMIT;
      end
      return 16'(t);
   endfunction

endpackage

>>> design/qrp_vector.sv
module qrp_vector #(
   parameter int IN_W = 34,
   parameter int STAGES = 16
) (
   input  logic                   clock,
   input  logic signed [IN_W-1:0] x_in,
   input  logic signed [IN_W-1:0] y_in,
   output qrp_pkg::ang_type       z_out
);
   import qrp_pkg::*;

   localparam int N = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;
   localparam int SH_W = $clog2(IN_W);

   logic [IN_W-1:0] abs_x, abs_y, mag;
   logic signed [IN_W-1:0] xa_ff, ya_ff;
   logic [IN_W-1:0] ma_ff;
   logic zero_a_ff;

   always_comb begin
      abs_x = x_in[IN_W-1] ? IN_W'(-x_in) : IN_W'(x_in);
      abs_y = y_in[IN_W-1] ? IN_W'(-y_in) : IN_W'(y_in);
      mag = (abs_x > abs_y) ? abs_x : abs_y;
   end

   always_ff @(posedge clock) begin
      xa_ff <= x_in;
      ya_ff <= y_in;
      ma_ff <= mag;
      zero_a_ff <= (x_in == '0) && (y_in == '0);
   end

   logic [SH_W-1:0] msb, sh_in;
   logic right_in;
   logic signed [IN_W-1:0] xb_ff, yb_ff;
   logic [SH_W-1:0] sh_b_ff;
   logic right_b_ff, zero_b_ff;

   always_comb begin
      msb = '0;
      for (int i = 0; i < IN_W; i++) begin
         if (ma_ff[i]) begin
            msb = SH_W'(i);
         end
      end
      right_in = (msb >= SH_W'(30));
      sh_in = right_in ? (msb - SH_W'(29)) : (SH_W'(29) - msb);
   end

   always_ff @(posedge clock) begin
      xb_ff <= xa_ff;
      yb_ff <= ya_ff;
      sh_b_ff <= sh_in;
      right_b_ff <= right_in;
      zero_b_ff <= zero_a_ff;
   end

   logic signed [IN_W-1:0] xs, ys;
   logic signed [NORM_W-1:0] xc_ff, yc_ff;
   logic zero_c_ff;

   always_comb begin
      xs = right_b_ff ? (xb_ff >>> sh_b_ff) : (xb_ff <<< sh_b_ff);
      ys = right_b_ff ? (yb_ff >>> sh_b_ff) : (yb_ff <<< sh_b_ff);
   end

   always_ff @(posedge clock) begin
      xc_ff <= NORM_W'(xs);
      yc_ff <= NORM_W'(ys);
      zero_c_ff <= zero_b_ff;
   end

   logic signed [ITER_W-1:0] x_ff [0:N];
   logic signed [ITER_W-1:0] y_ff [0:N];
   ang_type z_ff [0:N];
   logic zero_ff [0:N];

   always_ff @(posedge clock) begin
      if (xc_ff < 0) begin
         x_ff[0] <= -ITER_W'(xc_ff);
         y_ff[0] <= -ITER_W'(yc_ff);
         z_ff[0] <= (yc_ff >= 0) ? ANG_PI : -ANG_PI;
      end else begin
         x_ff[0] <= ITER_W'(xc_ff);
         y_ff[0] <= ITER_W'(yc_ff);
         z_ff[0] <= '0;
      end
      zero_ff[0] <= zero_c_ff;
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (y_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ATAN_TAB[i];
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ATAN_TAB[i];
         end
         zero_ff[i+1] <= zero_ff[i];
      end
   end

   assign z_out = zero_ff[N] ? '0 : z_ff[N];

endmodule

>>> design/qrp_rotate.sv
module qrp_rotate #(
   parameter int STAGES = 16
) (
   input  logic             clock,
   input  qrp_pkg::ang_type z_in,
   output qrp_pkg::rot_type cos_out,
   output qrp_pkg::rot_type sin_out
);
   import qrp_pkg::*;

   localparam int N = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;

   rot_type x_ff [0:N-1];
   rot_type y_ff [0:N-1];
   ang_type z_ff [0:N-1];

   for (genvar i = 0; i < N; i++) begin : g_iter
      rot_type xi, yi;
      ang_type zi;
      if (i == 0) begin : g_first
         assign xi = INV_GAIN;
         assign yi = '0;
         assign zi = z_in;
      end else begin : g_next
         assign xi = x_ff[i-1];
         assign yi = y_ff[i-1];
         assign zi = z_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (zi >= 0) begin
            x_ff[i] <= xi - (yi >>> i);
            y_ff[i] <= yi + (xi >>> i);
            z_ff[i] <= zi - ATAN_TAB[i];
         end else begin
            x_ff[i] <= xi + (yi >>> i);
            y_ff[i] <= yi - (xi >>> i);
            z_ff[i] <= zi + ATAN_TAB[i];
         end
      end
   end

   assign cos_out = x_ff[N-1];
   assign sin_out = y_ff[N-1];

endmodule

>>> design/quaternion_relative_pitch.sv
// Channel   Ports                          Handshake
// request   req_* (nine 16-bit fields)     taken when start is high and busy is low
// response  rsp_rel_pitch_angle, rsp_base_yaw_angle
//                                          rsp_valid high for one cycle per word
//
// A word can be taken on every clock cycle while busy is low; it passes through the
// three CORDIC pipelines of N iterations in series, N being CORDIC_STAGES capped at 24.
// Reset is synchronous and clears the valid chain; busy is high only around reset.
// The receiver cannot stall, so the pipeline never holds.
module quaternion_relative_pitch #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_chassis_w,
   input  logic signed [15:0] req_chassis_x,
   input  logic signed [15:0] req_chassis_y,
   input  logic signed [15:0] req_chassis_z,
   input  logic signed [15:0] req_gimbal_w,
   input  logic signed [15:0] req_gimbal_x,
   input  logic signed [15:0] req_gimbal_y,
   input  logic signed [15:0] req_gimbal_z,
   input  logic signed [15:0] req_rel_yaw_angle,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_rel_pitch_angle,
   output logic signed [15:0] rsp_base_yaw_angle
);
   import qrp_pkg::*;

   localparam int N = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int LV = N + 4;
   localparam int R_T = 2 * N + 9;
   localparam int P_T = 3 * N + 19;
   localparam int D_REL = 2 + LV;
   localparam int D_QUAT = R_T;
   localparam int D_G = R_T + 2;
   localparam int D_YAW = R_T + 4;

   function automatic err_type wrap_step(input err_type e);
      if (e > err_type'(ANG_PI)) begin
         return e - ANG_TWO_PI;
      end
      if (e < -err_type'(ANG_PI)) begin
         return e + ANG_TWO_PI;
      end
      return e;
   endfunction

   logic busy_ff;
   logic valid_ff [0:P_T];
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= P_T; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         busy_ff <= 1'b0;
         valid_ff[0] <= start && !busy_ff;
         for (int k = 1; k <= P_T; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         rsp_valid_ff <= valid_ff[P_T];
      end
   end

   assign busy = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   quat_type qc_ff, qg_ff;
   logic signed [15:0] rel_ff;

   always_ff @(posedge clock) begin
      qc_ff <= '{w: req_chassis_w, x: req_chassis_x, y: req_chassis_y, z: req_chassis_z};
      qg_ff <= '{w: req_gimbal_w, x: req_gimbal_x, y: req_gimbal_y, z: req_gimbal_z};
      rel_ff <= req_rel_yaw_angle;
   end

   logic signed [31:0] c_wz_ff, c_xy_ff, c_yy_ff, c_zz_ff;
   logic signed [31:0] g_wz_ff, g_xy_ff, g_yy_ff, g_zz_ff, g_xx_ff;
   logic signed [31:0] g_xz_ff, g_wy_ff, g_yz_ff, g_wx_ff;

   always_ff @(posedge clock) begin
      c_wz_ff <= qc_ff.w * qc_ff.z;
      c_xy_ff <= qc_ff.x * qc_ff.y;
      c_yy_ff <= qc_ff.y * qc_ff.y;
      c_zz_ff <= qc_ff.z * qc_ff.z;
      g_wz_ff <= qg_ff.w * qg_ff.z;
      g_xy_ff <= qg_ff.x * qg_ff.y;
      g_yy_ff <= qg_ff.y * qg_ff.y;
      g_zz_ff <= qg_ff.z * qg_ff.z;
      g_xx_ff <= qg_ff.x * qg_ff.x;
      g_xz_ff <= qg_ff.x * qg_ff.z;
      g_wy_ff <= qg_ff.w * qg_ff.y;
      g_yz_ff <= qg_ff.y * qg_ff.z;
      g_wx_ff <= qg_ff.w * qg_ff.x;
   end

   logic signed [35:0] s_cy, s_cx, s_gy, s_gx, s_g02, s_g20, s_g21, s_g22;
   logic signed [35:0] half_lsb;
   logic signed [YAW_W-1:0] cyaw_y_ff, cyaw_x_ff, gyaw_y_ff, gyaw_x_ff;
   gmat_type g_in, g_ff;

   always_comb begin
      half_lsb = 36'sd16384;
      s_cy = (36'(c_wz_ff) + 36'(c_xy_ff)) <<< 1;
      s_cx = UNIT_ONE - ((36'(c_yy_ff) + 36'(c_zz_ff)) <<< 1);
      s_gy = (36'(g_wz_ff) + 36'(g_xy_ff)) <<< 1;
      s_gx = UNIT_ONE - ((36'(g_yy_ff) + 36'(g_zz_ff)) <<< 1);
      s_g02 = (36'(g_xz_ff) - 36'(g_wy_ff)) <<< 1;
      s_g20 = (36'(g_xz_ff) + 36'(g_wy_ff)) <<< 1;
      s_g21 = (36'(g_yz_ff) - 36'(g_wx_ff)) <<< 1;
      s_g22 = UNIT_ONE - ((36'(g_xx_ff) + 36'(g_yy_ff)) <<< 1);
      g_in.g00 = G_W'((s_gx + half_lsb) >>> 15);
      g_in.g01 = G_W'((s_gy + half_lsb) >>> 15);
      g_in.g02 = G_W'((s_g02 + half_lsb) >>> 15);
      g_in.g20 = G_W'((s_g20 + half_lsb) >>> 15);
      g_in.g21 = G_W'((s_g21 + half_lsb) >>> 15);
      g_in.g22 = G_W'((s_g22 + half_lsb) >>> 15);
   end

   always_ff @(posedge clock) begin
      cyaw_y_ff <= YAW_W'(s_cy);
      cyaw_x_ff <= YAW_W'(s_cx);
      gyaw_y_ff <= YAW_W'(s_gy);
      gyaw_x_ff <= YAW_W'(s_gx);
      g_ff <= g_in;
   end

   ang_type base_yaw, gimbal_yaw;

   qrp_vector #(.IN_W(YAW_W), .STAGES(N)) u_vec_base (
      .clock (clock),
      .x_in  (cyaw_x_ff),
      .y_in  (cyaw_y_ff),
      .z_out (base_yaw)
   );

   qrp_vector #(.IN_W(YAW_W), .STAGES(N)) u_vec_gimbal (
      .clock (clock),
      .x_in  (gyaw_x_ff),
      .y_in  (gyaw_y_ff),
      .z_out (gimbal_yaw)
   );

   logic signed [15:0] rel_d_ff [0:D_REL-1];
   quat_type quat_d_ff [0:D_QUAT-1];
   gmat_type g_d_ff [0:D_G-1];
   ang_type yaw_d_ff [0:D_YAW-1];

   always_ff @(posedge clock) begin
      rel_d_ff[0] <= rel_ff;
      for (int k = 1; k < D_REL; k++) begin
         rel_d_ff[k] <= rel_d_ff[k-1];
      end
      quat_d_ff[0] <= qc_ff;
      for (int k = 1; k < D_QUAT; k++) begin
         quat_d_ff[k] <= quat_d_ff[k-1];
      end
      g_d_ff[0] <= g_ff;
      for (int k = 1; k < D_G; k++) begin
         g_d_ff[k] <= g_d_ff[k-1];
      end
      yaw_d_ff[0] <= base_yaw;
      for (int k = 1; k < D_YAW; k++) begin
         yaw_d_ff[k] <= yaw_d_ff[k-1];
      end
   end

   err_type err1_ff, err2_ff;
   ang_type half_ff;
   err_type err3;

   always_comb begin
      err3 = wrap_step(err2_ff);
   end

   always_ff @(posedge clock) begin
      err1_ff <= ERR_W'(gimbal_yaw) - ERR_W'(base_yaw)
                 - (ERR_W'(rel_d_ff[D_REL-1]) <<< 11);
      err2_ff <= wrap_step(err1_ff);
      half_ff <= ANG_W'(err3 >>> 1);
   end

   rot_type cs, sn;

   qrp_rotate #(.STAGES(N)) u_rot (
      .clock   (clock),
      .z_in    (half_ff),
      .cos_out (cs),
      .sin_out (sn)
   );

   quat_type qa;
   logic signed [48:0] m_cw_ff, m_sz_ff, m_cx_ff, m_sy_ff;
   logic signed [48:0] m_cy_ff, m_sx_ff, m_cz_ff, m_sw_ff;

   assign qa = quat_d_ff[D_QUAT-1];

   always_ff @(posedge clock) begin
      m_cw_ff <= cs * qa.w;
      m_sz_ff <= sn * qa.z;
      m_cx_ff <= cs * qa.x;
      m_sy_ff <= sn * qa.y;
      m_cy_ff <= cs * qa.y;
      m_sx_ff <= sn * qa.x;
      m_cz_ff <= cs * qa.z;
      m_sw_ff <= sn * qa.w;
   end

   logic signed [49:0] round30;
   logic signed [AQ_W-1:0] aw_ff, ax_ff, ay_ff, az_ff;

   assign round30 = 50'sd536870912;

   always_ff @(posedge clock) begin
      aw_ff <= AQ_W'((50'(m_cw_ff) - 50'(m_sz_ff) + round30) >>> 30);
      ax_ff <= AQ_W'((50'(m_cx_ff) - 50'(m_sy_ff) + round30) >>> 30);
      ay_ff <= AQ_W'((50'(m_cy_ff) + 50'(m_sx_ff) + round30) >>> 30);
      az_ff <= AQ_W'((50'(m_cz_ff) + 50'(m_sw_ff) + round30) >>> 30);
   end

   logic signed [2*AQ_W-1:0] p_xz_ff, p_wy_ff, p_yz_ff, p_wx_ff, p_xx_ff, p_yy_ff;

   always_ff @(posedge clock) begin
      p_xz_ff <= ax_ff * az_ff;
      p_wy_ff <= aw_ff * ay_ff;
      p_yz_ff <= ay_ff * az_ff;
      p_wx_ff <= aw_ff * ax_ff;
      p_xx_ff <= ax_ff * ax_ff;
      p_yy_ff <= ay_ff * ay_ff;
   end

   logic signed [R_W-1:0] r0_ff, r1_ff, r2_ff;

   always_ff @(posedge clock) begin
      r0_ff <= (R_W'(p_xz_ff) + R_W'(p_wy_ff)) <<< 1;
      r1_ff <= (R_W'(p_yz_ff) - R_W'(p_wx_ff)) <<< 1;
      r2_ff <= R_W'(UNIT_ONE) - ((R_W'(p_xx_ff) + R_W'(p_yy_ff)) <<< 1);
   end

   gmat_type gd;
   logic signed [R_W+G_W-1:0] t00_ff, t01_ff, t02_ff, t20_ff, t21_ff, t22_ff;

   assign gd = g_d_ff[D_G-1];

   always_ff @(posedge clock) begin
      t00_ff <= r0_ff * gd.g00;
      t01_ff <= r1_ff * gd.g01;
      t02_ff <= r2_ff * gd.g02;
      t20_ff <= r0_ff * gd.g20;
      t21_ff <= r1_ff * gd.g21;
      t22_ff <= r2_ff * gd.g22;
   end

   localparam int S_W = R_W + G_W + 2;

   logic signed [P_W-1:0] pv_y_ff, pv_x_ff;

   always_ff @(posedge clock) begin
      pv_y_ff <= P_W'(-(S_W'(t00_ff) + S_W'(t01_ff) + S_W'(t02_ff)));
      pv_x_ff <= P_W'(S_W'(t20_ff) + S_W'(t21_ff) + S_W'(t22_ff));
   end

   ang_type pitch;

   qrp_vector #(.IN_W(P_W), .STAGES(N)) u_vec_pitch (
      .clock (clock),
      .x_in  (pv_x_ff),
      .y_in  (pv_y_ff),
      .z_out (pitch)
   );

   logic signed [15:0] pitch_ff, yaw_ff;

   always_ff @(posedge clock) begin
      pitch_ff <= to_q13(pitch);
      yaw_ff <= to_q13(yaw_d_ff[D_YAW-1]);
   end

   assign rsp_rel_pitch_angle = pitch_ff;
   assign rsp_base_yaw_angle = yaw_ff;

endmodule

>>> design/qrp_checker.sv
module qrp_checker #(
   parameter int CORDIC_STAGES = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [15:0] rsp_rel_pitch_angle,
   input logic signed [15:0] rsp_base_yaw_angle
);

   localparam int N = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
   localparam int LAT = 3 * N + 21;

   a_word_returns: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted word produced no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response without a matching request");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rel_pitch_angle <= 16'sd25736 &&
                     rsp_rel_pitch_angle >= -16'sd25736))
      else $error("pitch outside saturation range");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_base_yaw_angle <= 16'sd25736 &&
                     rsp_base_yaw_angle >= -16'sd25736))
      else $error("yaw outside saturation range");

endmodule

bind quaternion_relative_pitch qrp_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import qrp_pkg::*;

   localparam int STAGES = 16;
   localparam int NSTAGE = STAGES < ATAN_LEN ? STAGES : ATAN_LEN;
   localparam int LATENCY = 3 * NSTAGE + 20;
   localparam int STALL_LIMIT = 20 * LATENCY + 2000;
   localparam longint ONE_SQ = 64'sd1073676289;
   localparam longint PI_24 = 64'sd52707179;
   localparam longint TWO_PI_24 = 64'sd105414357;

   typedef struct packed {
      logic signed [15:0] cw, cx, cy, cz;
      logic signed [15:0] gw, gx, gy, gz;
      logic signed [15:0] rel;
   } attitude_word;

   typedef struct packed {
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
   } pitch_word;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_chassis_w = '0, req_chassis_x = '0;
   logic signed [15:0] req_chassis_y = '0, req_chassis_z = '0;
   logic signed [15:0] req_gimbal_w = '0, req_gimbal_x = '0;
   logic signed [15:0] req_gimbal_y = '0, req_gimbal_z = '0;
   logic signed [15:0] req_rel_yaw_angle = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_rel_pitch_angle, rsp_base_yaw_angle;

   attitude_word pending_words[$];
   pitch_word expected_pitch[$];
   int mismatches = 0;
   int idle_pct = 34;
   int stall_cycles = 0;

   quaternion_relative_pitch #(.CORDIC_STAGES(STAGES)) dut (.*);

   always #4 clock = ~clock;

   function automatic longint rnd_shr(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, m, ax, ay, nx, ny;
      z = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      m = ax > ay ? ax : ay;
      while (m >= (64'sd1 <<< 30)) begin
         x = x >>> 1;
         y = y >>> 1;
         m = m >>> 1;
      end
      while (m < (64'sd1 <<< 29)) begin
         x = x * 2;
         y = y * 2;
         m = m * 2;
      end
      if (x < 0) begin
         z = (y >= 0) ? PI_24 : -PI_24;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < NSTAGE; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += longint'(ATAN_TAB[i]);
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= longint'(ATAN_TAB[i]);
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   function automatic logic signed [15:0] angle_q13(longint a);
      longint v;
      v = rnd_shr(a, 11);
      if (v > 25736) v = 25736;
      if (v < -25736) v = -25736;
      return 16'(v);
   endfunction

   function automatic pitch_word predict_pitch(attitude_word a);
      longint cw, cx, cy, cz, gw, gx, gy, gz;
      longint cyaw, gyaw, drift, x, y, z, nx, ny;
      longint aw, ax, ay, az, r0, r1, r2;
      longint g00, g01, g02, g20, g21, g22, r31, r33;
      pitch_word p;
      cw = a.cw; cx = a.cx; cy = a.cy; cz = a.cz;
      gw = a.gw; gx = a.gx; gy = a.gy; gz = a.gz;
      cyaw = vector_angle(2 * (cw * cz + cx * cy), ONE_SQ - 2 * (cy * cy + cz * cz));
      gyaw = vector_angle(2 * (gw * gz + gx * gy), ONE_SQ - 2 * (gy * gy + gz * gz));
      drift = gyaw - cyaw - longint'(a.rel) * 2048;
      while (drift > PI_24) drift -= TWO_PI_24;
      while (drift < -PI_24) drift += TWO_PI_24;
      z = drift >>> 1;
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < NSTAGE; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= longint'(ATAN_TAB[i]);
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += longint'(ATAN_TAB[i]);
         end
         x = nx;
         y = ny;
      end
      aw = rnd_shr(x * cw - y * cz, 30);
      ax = rnd_shr(x * cx - y * cy, 30);
      ay = rnd_shr(x * cy + y * cx, 30);
      az = rnd_shr(x * cz + y * cw, 30);
      r0 = 2 * (ax * az + aw * ay);
      r1 = 2 * (ay * az - aw * ax);
      r2 = ONE_SQ - 2 * (ax * ax + ay * ay);
      g00 = rnd_shr(ONE_SQ - 2 * (gy * gy + gz * gz), 15);
      g01 = rnd_shr(2 * (gx * gy + gw * gz), 15);
      g02 = rnd_shr(2 * (gx * gz - gw * gy), 15);
      g20 = rnd_shr(2 * (gx * gz + gw * gy), 15);
      g21 = rnd_shr(2 * (gy * gz - gw * gx), 15);
      g22 = rnd_shr(ONE_SQ - 2 * (gx * gx + gy * gy), 15);
      r31 = r0 * g00 + r1 * g01 + r2 * g02;
      r33 = r0 * g20 + r1 * g21 + r2 * g22;
      p.pitch = angle_q13(vector_angle(-r31, r33));
      p.yaw = angle_q13(cyaw);
      return p;
   endfunction

   function automatic logic signed [15:0] rand_part(bit wide);
      int sh;
      sh = $urandom_range(0, 6);
      if (wide) begin
         return 16'($urandom);
      end
      return 16'($signed(16'($urandom)) >>> sh);
   endfunction

   function automatic attitude_word rand_attitude();
      attitude_word a;
      bit wide;
      wide = ($urandom_range(0, 3) == 0);
      a.cw = rand_part(wide); a.cx = rand_part(wide);
      a.cy = rand_part(wide); a.cz = rand_part(wide);
      a.gw = rand_part(wide); a.gx = rand_part(wide);
      a.gy = rand_part(wide); a.gz = rand_part(wide);
      case ($urandom_range(0, 3))
         0: a.rel = 16'($urandom);
         default: a.rel = 16'($signed($urandom_range(0, 51472)) - 25736);
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_pitch.push_back(predict_pitch({req_chassis_w, req_chassis_x,
               req_chassis_y, req_chassis_z, req_gimbal_w, req_gimbal_x,
               req_gimbal_y, req_gimbal_z, req_rel_yaw_angle}));
         end
         if (!start || !busy) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               attitude_word a;
               a = pending_words.pop_front();
               start <= 1'b1;
               {req_chassis_w, req_chassis_x, req_chassis_y, req_chassis_z,
                req_gimbal_w, req_gimbal_x, req_gimbal_y, req_gimbal_z,
                req_rel_yaw_angle} <= a;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_pitch.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected word: pitch %0d yaw %0d",
                        rsp_rel_pitch_angle, rsp_base_yaw_angle);
            end
         end else begin
            pitch_word e;
            e = expected_pitch.pop_front();
            if (e.pitch !== rsp_rel_pitch_angle || e.yaw !== rsp_base_yaw_angle) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: pitch exp %0d got %0d, yaw exp %0d got %0d",
                           e.pitch, rsp_rel_pitch_angle, e.yaw, rsp_base_yaw_angle);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      attitude_word a;
      logic signed [15:0] edge_vals[6];
      edge_vals = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd23170};
      a = '0;
      pending_words.push_back(a);
      a.cw = 16'sh7FFF; a.gw = 16'sh7FFF;
      pending_words.push_back(a);
      for (int i = 0; i < 6; i++) begin
         a = '{edge_vals[i], edge_vals[(i + 1) % 6], edge_vals[(i + 2) % 6],
               edge_vals[(i + 3) % 6], edge_vals[(i + 4) % 6], edge_vals[(i + 5) % 6],
               edge_vals[i], edge_vals[(i + 2) % 6], edge_vals[i]};
         pending_words.push_back(a);
      end
      a = '1;
      a.rel = -16'sh8000;
      pending_words.push_back(a);
      a = {{8{16'sh7FFF}}, 16'sh7FFF};
      pending_words.push_back(a);
      a = {{8{-16'sh8000}}, 16'sd25736};
      pending_words.push_back(a);
      a = '0;
      a.cw = 16'sd23170; a.cz = 16'sd23170;
      a.gw = 16'sd23170; a.gy = 16'sd23170; a.rel = -16'sd25736;
      pending_words.push_back(a);
      a.cz = -16'sd23170; a.gy = -16'sd23170; a.rel = 16'sd12868;
      pending_words.push_back(a);
      a = '0;
      a.cw = -16'sh7FFF; a.gz = 16'sh7FFF; a.rel = 16'sd25736;
      pending_words.push_back(a);
      for (int i = 0; i < 1100; i++) begin
         pending_words.push_back(rand_attitude());
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_words.size() >= 700) @(posedge clock);
      idle_pct = 0;
      while (pending_words.size() >= 500) @(posedge clock);
      idle_pct = 34;
      while (!(pending_words.size() == 0 && !start && expected_pitch.size() == 0)) begin
         @(posedge clock);
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> quaternion_relative_pitch.f
design/qrp_pkg.sv
design/qrp_vector.sv
design/qrp_rotate.sv
design/quaternion_relative_pitch.sv
design/qrp_checker.sv
test/testbench.sv
